[rtl/sss_pkg.sv]
// Package for the scan servo sweep sequencer: item and result beat types,
// configuration register indexes, reset values and fixed arithmetic constants.
// Used by every module under rtl.
package sss_pkg;

  typedef enum logic [2:0] {
    CfgMinPulse  = 3'd0,
    CfgMaxPulse  = 3'd1,
    CfgStep      = 3'd2,
    CfgSettle    = 3'd3,
    CfgMinPoints = 3'd4,
    CfgSamples   = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    ReqTick  = 1'b0,
    ReqPoint = 1'b1
  } req_kind_e;

  typedef struct packed {
    logic        req_type;
    logic [11:0] angle_tenths;
  } req_t;

  typedef struct packed {
    logic        sample_done;
    logic        servo_moved;
    logic        settling;
    logic [14:0] pulse_width;
    logic [15:0] pwm_level;
    logic [15:0] points_done;
    logic [7:0]  sample_count;
  } rsp_t;

  typedef struct packed {
    logic [14:0] min_pulse;
    logic [14:0] max_pulse;
    logic [10:0] step_us;
    logic [15:0] settle_ticks;
    logic [15:0] min_points;
    logic [7:0]  samples_per_step;
  } cfg_t;

  localparam logic [14:0] MinPulseReset = 15'd500;
  localparam logic [14:0] MaxPulseReset = 15'd2500;
  localparam logic [10:0] StepReset     = 11'd10;
  localparam logic [15:0] SettleReset   = 16'd100;
  localparam logic [15:0] MinPointsReset = 16'd100;
  localparam logic [7:0]  SamplesReset  = 8'd1;
  localparam logic [14:0] PulseReset    = 15'd500;

  localparam logic [11:0] NearTenths = 12'd100;
  localparam logic [11:0] FarTenths  = 12'd3500;

  // Division by the 20000 us period: drop the factor 32 by a shift, then
  // multiply by a rounded-up reciprocal of 625 scaled by 2^36.
  localparam int unsigned PreShift   = 5;
  localparam int unsigned RecipShift = 36;
  localparam logic [26:0] RecipMul   = 27'd109951163;

endpackage

[rtl/sss_cfg.sv]
// Configuration register file of the scan servo sweep sequencer.
// Depends on sss_pkg for the register indexes, reset values and cfg_t.
module sss_cfg
  import sss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_pulse        <= MinPulseReset;
      cfg_q.max_pulse        <= MaxPulseReset;
      cfg_q.step_us          <= StepReset;
      cfg_q.settle_ticks     <= SettleReset;
      cfg_q.min_points       <= MinPointsReset;
      cfg_q.samples_per_step <= SamplesReset;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgMinPulse:  cfg_q.min_pulse        <= cfg_data_i[14:0];
        CfgMaxPulse:  cfg_q.max_pulse        <= cfg_data_i[14:0];
        CfgStep:      cfg_q.step_us          <= cfg_data_i[10:0];
        CfgSettle:    cfg_q.settle_ticks     <= cfg_data_i;
        CfgMinPoints: cfg_q.min_points       <= cfg_data_i;
        CfgSamples:   cfg_q.samples_per_step <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/sss_core.sv]
// Sweep state and per-beat update: settle countdown, rotation detection and
// servo stepping, with a registered result beat. Depends on sss_pkg.
module sss_core
  import sss_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output rsp_t res_data_o
);

  logic        res_valid_q;
  rsp_t        res_q, res_d;
  logic [14:0] pulse_q, pulse_d;
  logic        down_q, down_d;
  logic        settle_q, settle_d;
  logic [15:0] left_q, left_d;
  logic        armed_q, armed_d;
  logic [11:0] start_q, start_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  done_q, done_d;

  logic        accept;
  logic        adv;
  logic [15:0] count_inc;
  logic [11:0] diff;
  logic        move;
  logic [16:0] np;

  assign adv        = !res_valid_q || res_ready_i;
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  assign count_inc = (count_q != 16'hFFFF) ? count_q + 16'd1 : count_q;
  assign diff = (in_data_i.angle_tenths >= start_q) ? in_data_i.angle_tenths - start_q
                                                    : start_q - in_data_i.angle_tenths;

  always_comb begin
    pulse_d  = pulse_q;
    down_d   = down_q;
    settle_d = settle_q;
    left_d   = left_q;
    armed_d  = armed_q;
    start_d  = start_q;
    count_d  = count_q;
    done_d   = done_q;
    res_d    = '0;
    move     = 1'b0;
    np       = '0;

    if (in_data_i.req_type == ReqTick) begin
      if (settle_q) begin
        if (left_q != 16'd0) begin
          left_d = left_q - 16'd1;
        end
        if (left_d == 16'd0) begin
          settle_d = 1'b0;
        end
      end
    end else if (!settle_q) begin
      if (!armed_q) begin
        armed_d = 1'b1;
        start_d = in_data_i.angle_tenths;
        count_d = 16'd1;
      end else begin
        count_d = count_inc;
        if (count_inc >= cfg_i.min_points) begin
          if (diff < NearTenths || diff > FarTenths) begin
            if (done_q != 8'hFF) begin
              done_d = done_q + 8'd1;
            end
            res_d.sample_done = 1'b1;
            res_d.points_done = count_inc;
            count_d = 16'd0;
            armed_d = 1'b0;
          end
        end
      end
    end

    if (!settle_d && done_d >= cfg_i.samples_per_step) begin
      move = 1'b1;
      np = down_q ? {2'b00, pulse_q} - {6'd0, cfg_i.step_us}
                  : {2'b00, pulse_q} + {6'd0, cfg_i.step_us};
      if ($signed(np) >= $signed({2'b00, cfg_i.max_pulse})) begin
        np     = {2'b00, cfg_i.max_pulse};
        down_d = 1'b1;
      end else if ($signed(np) <= $signed({2'b00, cfg_i.min_pulse})) begin
        np     = {2'b00, cfg_i.min_pulse};
        down_d = 1'b0;
      end
      pulse_d  = np[14:0];
      done_d   = 8'd0;
      count_d  = 16'd0;
      start_d  = 12'd0;
      armed_d  = 1'b0;
      settle_d = 1'b1;
      left_d   = cfg_i.settle_ticks;
    end

    res_d.servo_moved  = move;
    res_d.settling     = settle_d;
    res_d.pulse_width  = pulse_d;
    res_d.pwm_level    = 16'd0;
    res_d.sample_count = done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      res_q       <= '0;
      pulse_q     <= PulseReset;
      down_q      <= 1'b0;
      settle_q    <= 1'b0;
      left_q      <= 16'd0;
      armed_q     <= 1'b0;
      start_q     <= 12'd0;
      count_q     <= 16'd0;
      done_q      <= 8'd0;
    end else begin
      if (adv) begin
        res_valid_q <= in_valid_i;
      end
      if (accept) begin
        res_q    <= res_d;
        pulse_q  <= pulse_d;
        down_q   <= down_d;
        settle_q <= settle_d;
        left_q   <= left_d;
        armed_q  <= armed_d;
        start_q  <= start_d;
        count_q  <= count_d;
        done_q   <= done_d;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_data_o  = res_q;

endmodule

[rtl/sss_pwm.sv]
// Two-stage PWM compare level pipeline: pulse times wrap, then division by
// the servo period through a reciprocal multiply, with saturation.
// Depends on sss_pkg.
module sss_pwm
  import sss_pkg::*;
#(
  parameter logic [15:0] PWM_WRAP = 16'd62499
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  rsp_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  logic        va_q, vb_q;
  rsp_t        a_q, b_q, b_d;
  logic [30:0] prod_q;
  logic        adv_a, adv_b;
  logic [52:0] scaled;
  logic [16:0] quot;

  assign adv_b      = !vb_q || !out_stall_i;
  assign adv_a      = !va_q || adv_b;
  assign in_ready_o = adv_a;

  assign scaled = {1'b0, prod_q[30:PreShift]} * {26'd0, RecipMul};
  assign quot   = scaled[RecipShift +: 17];

  always_comb begin
    b_d = a_q;
    b_d.pwm_level = (quot > 17'h0FFFF) ? 16'hFFFF : quot[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q   <= 1'b0;
      vb_q   <= 1'b0;
      a_q    <= '0;
      b_q    <= '0;
      prod_q <= '0;
    end else begin
      if (adv_a) begin
        va_q <= in_valid_i;
        if (in_valid_i) begin
          a_q    <= in_data_i;
          prod_q <= {16'd0, in_data_i.pulse_width} * {15'd0, PWM_WRAP};
        end
      end
      if (adv_b) begin
        vb_q <= va_q;
        if (va_q) begin
          b_q <= b_d;
        end
      end
    end
  end

  assign out_valid_o = vb_q;
  assign out_data_o  = b_q;

endmodule

[rtl/scan_servo_sweep_sequencer.sv]
// Top level of the scan servo sweep sequencer: configuration registers,
// sweep core and PWM level pipeline. Depends on sss_pkg, sss_cfg, sss_core
// and sss_pwm.
//
// Usage: each input beat is either a millisecond tick or a scanner point
// with its angle in tenths of a degree. Every accepted beat yields exactly
// one result beat holding the sample and move flags, the settle flag, the
// servo pulse width, its PWM compare level and the sample counters.
// A beat is taken when in_valid_i is high and in_stall_o is low; a result
// is taken when out_valid_o is high and out_stall_i is low.
// The core registers the state update; the multiply and reciprocal divide
// that give the PWM level each get a stage of their own. Throughput is one
// beat per cycle; in_stall_o rises only when all three result stages are
// full and out_stall_i holds the output. A stalled result stays unchanged.
// Configuration writes are always accepted (cfg_ready_o is tied high) and
// should be made only while no beat is in flight.
// Reset is asynchronous and active low; it loads the default limits, puts
// the servo at the 500 us lower limit sweeping upwards and empties the
// pipeline.
module scan_servo_sweep_sequencer
  import sss_pkg::*;
#(
  parameter logic [15:0] PWM_WRAP = 16'd62499
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rsp_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t cfg;
  logic res_valid;
  logic res_ready;
  rsp_t res_data;

  sss_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sss_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data)
  );

  sss_pwm #(
    .PWM_WRAP (PWM_WRAP)
  ) u_pwm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_ready_o  (res_ready),
    .in_data_i   (res_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_move_settles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.servo_moved |-> out_data_o.settling)
    else $error("servo move without settling");

  a_done_points: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.sample_done == (out_data_o.points_done != 16'd0)))
    else $error("completed point count disagrees with sample flag");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output is free");

endmodule
